// File: rtl/mdb_peripheral_frame_parser_core_macros.svh
// assertion macros for the frame parser checker
`ifndef MDB_PERIPHERAL_FRAME_PARSER_CORE_MACROS_SVH
`define MDB_PERIPHERAL_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication on the clock and reset of the enclosing module
`define MDBFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the clock and reset of the enclosing module
`define MDBFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mdbfp_pkg.sv
// shared constants, codes and types of the frame parser
package mdbfp_pkg;

   localparam int MAX_FRAME_DEF       = 36;
   localparam int NUM_COMMANDS_DEF    = 8;
   localparam int NUM_SUBCOMMANDS_DEF = 8;
   localparam int SUB_SLOTS           = 8;
   localparam logic [4:0] DEV_ADDR_RST = 5'd2;

   typedef enum logic [2:0] {
      ST_BYTE,
      ST_CSUM_BAD,
      ST_NO_HANDLER,
      ST_UNKNOWN,
      ST_OVERFLOW
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_CSUM,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DATA,
      S_LEN,
      S_CSUM,
      S_CHECK,
      S_ERR,
      S_RD,
      S_WR
   } fsm_type;

   typedef struct packed {
      logic       valid;
      logic       has_sub;
      logic [5:0] length;
      logic       handler;
   } top_entry_type;

   typedef struct packed {
      logic [5:0] length;
      logic       handler;
   } sub_data_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] length;
      logic       handler;
   } sub_entry_type;

   typedef struct packed {
      logic       we;
      logic [2:0] command;
      logic       uses_sub;
      logic [2:0] subcommand;
      logic [5:0] length;
      logic       handler;
   } def_write_type;

   typedef struct packed {
      logic       re;
      logic [2:0] command;
      logic [7:0] subcommand;
   } sub_read_type;

endpackage

// File: rtl/mdbfp_ifs.sv
// handshake interfaces for the request, response and register channels
interface mdbfp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [8:0] bus_word;
   logic [2:0] def_command;
   logic       def_uses_sub;
   logic [2:0] def_subcommand;
   logic [5:0] def_length;
   logic       def_has_handler;

   modport source (
      output valid, cmd, bus_word, def_command, def_uses_sub, def_subcommand,
      output def_length, def_has_handler,
      input  ready
   );
   modport sink (
      input  valid, cmd, bus_word, def_command, def_uses_sub, def_subcommand,
      input  def_length, def_has_handler,
      output ready
   );
endinterface

interface mdbfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [2:0] command_code;
   logic [7:0] subcommand_code;
   logic [7:0] byte_value;
   logic [5:0] byte_index;
   logic       last;

   modport source (
      output valid, status, command_code, subcommand_code, byte_value, byte_index, last,
      input  ready
   );
   modport sink (
      input  valid, status, command_code, subcommand_code, byte_value, byte_index, last,
      output ready
   );
endinterface

interface mdbfp_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] device_address;

   modport source (
      output valid, device_address,
      input  ready
   );
   modport sink (
      input  valid, device_address,
      output ready
   );
endinterface

// File: rtl/mdbfp_cmd_table.sv
// command table: top entries in registers, subcommand entries in a synchronous ram
module mdbfp_cmd_table #(
   parameter int NUM_COMMANDS    = mdbfp_pkg::NUM_COMMANDS_DEF,
   parameter int NUM_SUBCOMMANDS = mdbfp_pkg::NUM_SUBCOMMANDS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mdbfp_pkg::def_write_type def_wr,
   input  logic [2:0]               top_idx,
   output mdbfp_pkg::top_entry_type top_rd,
   input  mdbfp_pkg::sub_read_type  sub_rd,
   output mdbfp_pkg::sub_entry_type sub_rd_data
);

   localparam int CMD_W   = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
   localparam int SUB_LIM = (NUM_SUBCOMMANDS < mdbfp_pkg::SUB_SLOTS) ?
                            NUM_SUBCOMMANDS : mdbfp_pkg::SUB_SLOTS;
   localparam int SUB_DEPTH = NUM_COMMANDS * mdbfp_pkg::SUB_SLOTS;
   localparam int SUB_AW    = $clog2(SUB_DEPTH);
   localparam logic [3:0] CMD_LIM = 4'(NUM_COMMANDS);
   localparam logic [7:0] SUB_CAP = 8'(SUB_LIM);

   mdbfp_pkg::top_entry_type top_ff [NUM_COMMANDS];
   mdbfp_pkg::sub_data_type  sub_mem [SUB_DEPTH];
   logic [SUB_DEPTH-1:0]     sub_valid_ff;
   mdbfp_pkg::sub_data_type  sub_q_ff;
   logic                     sub_hit_ff;

   logic              def_ok;
   logic [5:0]        wr_addr6;
   logic [SUB_AW-1:0] wr_addr;
   logic [5:0]        rd_addr6;
   logic [SUB_AW-1:0] rd_addr;
   logic              rd_in_range;

   assign def_ok = def_wr.we && ({1'b0, def_wr.command} < CMD_LIM) &&
                   (!def_wr.uses_sub || ({5'b0, def_wr.subcommand} < SUB_CAP));
   assign wr_addr6 = {def_wr.command, def_wr.subcommand};
   assign wr_addr  = wr_addr6[SUB_AW-1:0];
   assign rd_addr6 = {sub_rd.command, sub_rd.subcommand[2:0]};
   assign rd_addr  = rd_addr6[SUB_AW-1:0];
   assign rd_in_range = (sub_rd.subcommand < SUB_CAP);

   always_comb begin
      if ({1'b0, top_idx} < CMD_LIM) begin
         top_rd = top_ff[top_idx[CMD_W-1:0]];
      end else begin
         top_rd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COMMANDS; i++) begin
            top_ff[i] <= '0;
         end
         sub_valid_ff <= '0;
      end else if (def_ok) begin
         if (def_wr.uses_sub) begin
            top_ff[def_wr.command[CMD_W-1:0]].valid   <= 1'b1;
            top_ff[def_wr.command[CMD_W-1:0]].has_sub <= 1'b1;
            top_ff[def_wr.command[CMD_W-1:0]].handler <= 1'b0;
            sub_valid_ff[wr_addr] <= 1'b1;
         end else begin
            top_ff[def_wr.command[CMD_W-1:0]].valid   <= 1'b1;
            top_ff[def_wr.command[CMD_W-1:0]].has_sub <= 1'b0;
            top_ff[def_wr.command[CMD_W-1:0]].length  <= def_wr.length;
            top_ff[def_wr.command[CMD_W-1:0]].handler <= def_wr.handler;
         end
      end
   end

   // subcommand ram, one write and one registered read port
   always_ff @(posedge clock) begin
      if (def_ok && def_wr.uses_sub) begin
         sub_mem[wr_addr] <= '{length: def_wr.length, handler: def_wr.handler};
      end
      if (sub_rd.re) begin
         sub_q_ff <= sub_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_hit_ff <= 1'b0;
      end else if (sub_rd.re) begin
         sub_hit_ff <= sub_valid_ff[rd_addr] && rd_in_range;
      end
   end

   assign sub_rd_data.hit     = sub_hit_ff;
   assign sub_rd_data.length  = sub_q_ff.length;
   assign sub_rd_data.handler = sub_q_ff.handler;

endmodule

// File: rtl/mdbfp_frame_ram.sv
// frame byte store, one write port and one registered read port
module mdbfp_frame_ram #(
   parameter int MAX_FRAME = mdbfp_pkg::MAX_FRAME_DEF
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(MAX_FRAME)-1:0] waddr,
   input  logic [7:0]                   wdata,
   input  logic                         re,
   input  logic [$clog2(MAX_FRAME)-1:0] raddr,
   output logic [7:0]                   rdata
);

   logic [7:0] mem [MAX_FRAME];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/mdb_peripheral_frame_parser_core.sv
// frame parser top level: sequencer around the command table and frame store
// a table definition is written when taken; no item is taken while a bus word is in work
// a good checksum word emits each held byte via a frame ram read in S_RD, loaded out in S_WR
// error results are loaded into the output from S_ERR once the output is free
// reset clears control state and marks all table entries invalid
module mdb_peripheral_frame_parser_core #(
   parameter int MAX_FRAME       = mdbfp_pkg::MAX_FRAME_DEF,
   parameter int NUM_COMMANDS    = mdbfp_pkg::NUM_COMMANDS_DEF,
   parameter int NUM_SUBCOMMANDS = mdbfp_pkg::NUM_SUBCOMMANDS_DEF
) (
   input logic         clock,
   input logic         reset,
   mdbfp_req_if.sink   req_if,
   mdbfp_rsp_if.source rsp_if,
   mdbfp_csr_if.sink   csr_if
);

   localparam int IDX_W = $clog2(MAX_FRAME);
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int CW    = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   mdbfp_pkg::fsm_type    state_ff, state_in;
   mdbfp_pkg::phase_type  phase_ff, phase_in;
   logic [4:0]            dev_addr_ff;
   logic [8:0]            word_ff, word_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [7:0]            sub_ff, sub_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   mdbfp_pkg::status_type err_status_ff, err_status_in;
   logic [2:0]            err_cmd_ff, err_cmd_in;
   logic [7:0]            err_sub_ff, err_sub_in;

   logic                  rsp_valid_ff;
   mdbfp_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [2:0]            rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]            rsp_sub_ff, rsp_sub_in;
   logic [7:0]            rsp_value_ff, rsp_value_in;
   logic [5:0]            rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_load;

   mdbfp_pkg::def_write_type def_wr;
   mdbfp_pkg::top_entry_type top_e;
   mdbfp_pkg::sub_read_type  sub_rd;
   mdbfp_pkg::sub_entry_type sub_e;
   logic [2:0]               top_idx;

   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_rdata;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] run_inc;
   logic [7:0]       data;
   logic             req_take;
   logic             load_ok;
   logic             addr_match;
   logic             cmd_known;
   logic             overflow;
   logic             sub_latch;
   logic             sub_active;
   logic [5:0]       pick_len;
   logic             pick_hh;
   logic             len_match;
   logic             run_last;

   assign data       = word_ff[7:0];
   assign req_take   = req_if.valid && (state_ff == mdbfp_pkg::S_IDLE);
   assign load_ok    = !rsp_valid_ff || rsp_if.ready;
   assign addr_match = (word_ff[7:3] == dev_addr_ff);
   assign cmd_known  = top_e.valid;
   assign overflow   = (count_ff >= CNT_MAX);
   assign count_inc  = count_ff + CNT_ONE;
   assign run_inc    = run_ff + CNT_ONE;
   assign sub_latch  = (count_inc == CNT_TWO) && top_e.has_sub;
   assign run_last   = (run_inc == count_ff);

   // entry that governs the current frame
   assign sub_active = top_e.has_sub && (count_ff >= CNT_TWO);
   always_comb begin
      if (sub_active) begin
         pick_len = sub_e.hit ? sub_e.length : 6'd0;
         pick_hh  = sub_e.hit && sub_e.handler;
      end else begin
         pick_len = top_e.valid ? top_e.length : 6'd0;
         pick_hh  = top_e.valid && top_e.handler;
      end
   end
   assign len_match = (CW'(count_ff) == CW'(pick_len));

   assign top_idx = (state_ff == mdbfp_pkg::S_DECODE) ? word_ff[2:0] : cmd_ff;

   assign def_wr.we         = req_take && req_if.cmd;
   assign def_wr.command    = req_if.def_command;
   assign def_wr.uses_sub   = req_if.def_uses_sub;
   assign def_wr.subcommand = req_if.def_subcommand;
   assign def_wr.length     = req_if.def_length;
   assign def_wr.handler    = req_if.def_has_handler;

   assign sub_rd.re         = (state_ff == mdbfp_pkg::S_DATA) ||
                              (state_ff == mdbfp_pkg::S_CSUM);
   assign sub_rd.command    = cmd_ff;
   assign sub_rd.subcommand = ((state_ff == mdbfp_pkg::S_DATA) && sub_latch) ? data : sub_ff;

   assign ram_we = (state_ff == mdbfp_pkg::S_DATA) && !overflow;
   assign ram_re = (state_ff == mdbfp_pkg::S_RD);

   mdbfp_cmd_table #(
      .NUM_COMMANDS    (NUM_COMMANDS),
      .NUM_SUBCOMMANDS (NUM_SUBCOMMANDS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .def_wr      (def_wr),
      .top_idx     (top_idx),
      .top_rd      (top_e),
      .sub_rd      (sub_rd),
      .sub_rd_data (sub_e)
   );

   mdbfp_frame_ram #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (data),
      .re    (ram_re),
      .raddr (run_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdbfp_pkg::S_IDLE: begin
            if (req_take && !req_if.cmd) begin
               state_in = mdbfp_pkg::S_DECODE;
            end
         end
         mdbfp_pkg::S_DECODE: begin
            if (word_ff[8]) begin
               if (!addr_match) begin
                  state_in = mdbfp_pkg::S_IDLE;
               end else if (!cmd_known) begin
                  state_in = mdbfp_pkg::S_ERR;
               end else begin
                  state_in = mdbfp_pkg::S_DATA;
               end
            end else if (phase_ff == mdbfp_pkg::PH_DATA) begin
               state_in = mdbfp_pkg::S_DATA;
            end else if (phase_ff == mdbfp_pkg::PH_CSUM) begin
               state_in = mdbfp_pkg::S_CSUM;
            end else begin
               state_in = mdbfp_pkg::S_IDLE;
            end
         end
         mdbfp_pkg::S_DATA: begin
            state_in = overflow ? mdbfp_pkg::S_ERR : mdbfp_pkg::S_LEN;
         end
         mdbfp_pkg::S_LEN: begin
            state_in = mdbfp_pkg::S_IDLE;
         end
         mdbfp_pkg::S_CSUM: begin
            state_in = (sum_ff != data) ? mdbfp_pkg::S_ERR : mdbfp_pkg::S_CHECK;
         end
         mdbfp_pkg::S_CHECK: begin
            state_in = pick_hh ? mdbfp_pkg::S_RD : mdbfp_pkg::S_ERR;
         end
         mdbfp_pkg::S_ERR: begin
            if (load_ok) begin
               state_in = mdbfp_pkg::S_IDLE;
            end
         end
         mdbfp_pkg::S_RD: begin
            state_in = mdbfp_pkg::S_WR;
         end
         mdbfp_pkg::S_WR: begin
            if (load_ok) begin
               state_in = run_last ? mdbfp_pkg::S_IDLE : mdbfp_pkg::S_RD;
            end
         end
         default: begin
            state_in = mdbfp_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      word_in       = word_ff;
      phase_in      = phase_ff;
      cmd_in        = cmd_ff;
      sub_in        = sub_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      run_in        = run_ff;
      err_status_in = err_status_ff;
      err_cmd_in    = err_cmd_ff;
      err_sub_in    = err_sub_ff;
      out_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_sub_in    = rsp_sub_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         mdbfp_pkg::S_IDLE: begin
            if (req_take && !req_if.cmd) begin
               word_in = req_if.bus_word;
            end
         end
         mdbfp_pkg::S_DECODE: begin
            if (word_ff[8]) begin
               phase_in = mdbfp_pkg::PH_IDLE;
               sub_in   = 8'd0;
               count_in = '0;
               sum_in   = 8'd0;
               if (addr_match) begin
                  if (!cmd_known) begin
                     cmd_in        = 3'd0;
                     err_status_in = mdbfp_pkg::ST_UNKNOWN;
                     err_cmd_in    = word_ff[2:0];
                     err_sub_in    = 8'd0;
                  end else begin
                     cmd_in   = word_ff[2:0];
                     phase_in = mdbfp_pkg::PH_DATA;
                  end
               end
            end
         end
         mdbfp_pkg::S_DATA: begin
            if (overflow) begin
               err_status_in = mdbfp_pkg::ST_OVERFLOW;
               err_cmd_in    = cmd_ff;
               err_sub_in    = sub_ff;
               phase_in      = mdbfp_pkg::PH_IDLE;
               sub_in        = 8'd0;
               count_in      = '0;
               sum_in        = 8'd0;
            end else begin
               count_in = count_inc;
               sum_in   = sum_ff + data;
               if (sub_latch) begin
                  sub_in = data;
               end
            end
         end
         mdbfp_pkg::S_LEN: begin
            if (len_match) begin
               phase_in = mdbfp_pkg::PH_CSUM;
            end
         end
         mdbfp_pkg::S_CSUM: begin
            if (sum_ff != data) begin
               err_status_in = mdbfp_pkg::ST_CSUM_BAD;
               err_cmd_in    = cmd_ff;
               err_sub_in    = sub_ff;
               phase_in      = mdbfp_pkg::PH_IDLE;
               sub_in        = 8'd0;
               count_in      = '0;
               sum_in        = 8'd0;
            end
         end
         mdbfp_pkg::S_CHECK: begin
            if (pick_hh) begin
               phase_in = mdbfp_pkg::PH_DONE;
               run_in   = '0;
            end else begin
               err_status_in = mdbfp_pkg::ST_NO_HANDLER;
               err_cmd_in    = cmd_ff;
               err_sub_in    = sub_ff;
               phase_in      = mdbfp_pkg::PH_IDLE;
               sub_in        = 8'd0;
               count_in      = '0;
               sum_in        = 8'd0;
            end
         end
         mdbfp_pkg::S_ERR: begin
            if (load_ok) begin
               out_load      = 1'b1;
               rsp_status_in = err_status_ff;
               rsp_cmd_in    = err_cmd_ff;
               rsp_sub_in    = err_sub_ff;
               rsp_value_in  = data;
               rsp_index_in  = 6'd0;
               rsp_last_in   = 1'b1;
            end
         end
         mdbfp_pkg::S_RD: begin
         end
         mdbfp_pkg::S_WR: begin
            if (load_ok) begin
               out_load      = 1'b1;
               rsp_status_in = mdbfp_pkg::ST_BYTE;
               rsp_cmd_in    = cmd_ff;
               rsp_sub_in    = sub_ff;
               rsp_value_in  = ram_rdata;
               rsp_index_in  = 6'(run_ff);
               rsp_last_in   = run_last;
               run_in        = run_inc;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdbfp_pkg::S_IDLE;
         phase_ff     <= mdbfp_pkg::PH_IDLE;
         cmd_ff       <= 3'd0;
         sub_ff       <= 8'd0;
         count_ff     <= '0;
         sum_ff       <= 8'd0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dev_addr_ff  <= mdbfp_pkg::DEV_ADDR_RST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         run_ff   <= run_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_if.valid) begin
            dev_addr_ff <= csr_if.device_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      err_status_ff <= err_status_in;
      err_cmd_ff    <= err_cmd_in;
      err_sub_ff    <= err_sub_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_sub_ff    <= rsp_sub_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_if.ready           = (state_ff == mdbfp_pkg::S_IDLE);
   assign csr_if.ready           = 1'b1;
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.command_code    = rsp_cmd_ff;
   assign rsp_if.subcommand_code = rsp_sub_ff;
   assign rsp_if.byte_value      = rsp_value_ff;
   assign rsp_if.byte_index      = rsp_index_ff;
   assign rsp_if.last            = rsp_last_ff;

endmodule

// File: rtl/mdbfp_checker.sv
// port-level checker for the frame parser and its bind
`include "mdb_peripheral_frame_parser_core_macros.svh"

module mdbfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_byte_index,
   input logic       rsp_last
);

   logic rsp_is_byte;

   assign rsp_is_byte = (rsp_status == mdbfp_pkg::ST_BYTE);

   // a stalled item stays offered
   `MDBFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")

   // error items stand alone
   `MDBFP_ASSERT_NOW(a_err_shape, rsp_valid && !rsp_is_byte, rsp_last && (rsp_byte_index == 6'd0), "error item not single")

   // no new item is taken in the middle of a frame run
   `MDBFP_ASSERT_NOW(a_run_busy, rsp_valid && rsp_is_byte && !rsp_last, !req_ready, "item taken during run")

endmodule

bind mdb_peripheral_frame_parser_core mdbfp_checker u_mdbfp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_byte_index (rsp_if.byte_index),
   .rsp_last       (rsp_if.last)
);

// File: dv/tb.sv
// testbench for the frame parser: table defines, bus word frames, checked against a parser model
module tb;

   localparam int MAXF = mdbfp_pkg::MAX_FRAME_DEF;
   localparam int NSUB = mdbfp_pkg::NUM_SUBCOMMANDS_DEF;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic       cmd;
      logic [8:0] word;
      logic [2:0] d_cmd;
      logic       d_sub_en;
      logic [2:0] d_sub;
      logic [5:0] d_len;
      logic       d_hdl;
   } parser_item_type;

   typedef struct packed {
      mdbfp_pkg::status_type status;
      logic [2:0] cmd;
      logic [7:0] sub;
      logic [7:0] value;
      logic [5:0] index;
      logic       last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;

   mdbfp_req_if req_if ();
   mdbfp_rsp_if rsp_if ();
   mdbfp_csr_if csr_if ();

   mdb_peripheral_frame_parser_core dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #10 clock = ~clock;

   // parser model state
   logic [4:0] node_addr = mdbfp_pkg::DEV_ADDR_RST;
   mdbfp_pkg::phase_type ph = mdbfp_pkg::PH_IDLE;
   logic [2:0] cur_cmd = '0;
   logic [7:0] cur_sub = '0;
   int         held = 0;
   logic [7:0] sum = '0;
   logic [7:0] frame_bytes [MAXF];
   bit         tbl_valid [8];
   bit         tbl_has_sub [8];
   bit [5:0]   tbl_len [8];
   bit         tbl_hdl [8];
   bit         sub_valid [8][8];
   bit [5:0]   sub_len [8][8];
   bit         sub_hdl [8][8];

   frame_result_type results_due [$];
   parser_item_type  items_queued [$];
   parser_item_type  bus_item;
   int items_sent = 0;
   int items_taken = 0;
   int mismatches = 0;
   int send_gap = 0;
   int burst_left = 1;
   int quiet_cycles = 0;
   logic [15:0] stall_pat = 16'hFFFF;
   logic [3:0]  pat_pos = '0;

   function automatic void add_due(input mdbfp_pkg::status_type st, input logic [2:0] c,
                                   input logic [7:0] s, input logic [7:0] v,
                                   input logic [5:0] idx, input logic lst);
      frame_result_type r;
      r = '{st, c, s, v, idx, lst};
      results_due.push_back(r);
   endfunction

   function automatic void drop_frame();
      ph = mdbfp_pkg::PH_IDLE;
      cur_sub = '0;
      held = 0;
      sum = '0;
   endfunction

   function automatic void entry_limits(output int len, output bit hdl);
      len = 0;
      hdl = 1'b0;
      if (tbl_has_sub[cur_cmd] && held >= 2) begin
         if (cur_sub < NSUB && sub_valid[cur_cmd][cur_sub[2:0]]) begin
            len = sub_len[cur_cmd][cur_sub[2:0]];
            hdl = sub_hdl[cur_cmd][cur_sub[2:0]];
         end
      end else if (tbl_valid[cur_cmd]) begin
         len = tbl_len[cur_cmd];
         hdl = tbl_hdl[cur_cmd];
      end
   endfunction

   function automatic void step_parser(input parser_item_type it);
      logic [7:0] data;
      int len;
      bit hdl;
      data = it.word[7:0];
      if (it.cmd) begin
         tbl_valid[it.d_cmd] = 1'b1;
         if (it.d_sub_en) begin
            tbl_has_sub[it.d_cmd] = 1'b1;
            tbl_hdl[it.d_cmd] = 1'b0;
            sub_valid[it.d_cmd][it.d_sub] = 1'b1;
            sub_len[it.d_cmd][it.d_sub] = it.d_len;
            sub_hdl[it.d_cmd][it.d_sub] = it.d_hdl;
         end else begin
            tbl_has_sub[it.d_cmd] = 1'b0;
            tbl_len[it.d_cmd] = it.d_len;
            tbl_hdl[it.d_cmd] = it.d_hdl;
         end
         return;
      end
      if (it.word[8]) begin
         drop_frame();
         if (it.word[7:3] != node_addr) return;
         if (!tbl_valid[it.word[2:0]]) begin
            cur_cmd = '0;
            add_due(mdbfp_pkg::ST_UNKNOWN, it.word[2:0], 8'd0, data, 6'd0, 1'b1);
            return;
         end
         cur_cmd = it.word[2:0];
         ph = mdbfp_pkg::PH_DATA;
      end
      if (ph == mdbfp_pkg::PH_DATA) begin
         if (held >= MAXF) begin
            add_due(mdbfp_pkg::ST_OVERFLOW, cur_cmd, cur_sub, data, 6'd0, 1'b1);
            drop_frame();
            return;
         end
         frame_bytes[held] = data;
         held++;
         sum += data;
         if (held == 2 && tbl_has_sub[cur_cmd]) cur_sub = data;
         entry_limits(len, hdl);
         if (held == len) ph = mdbfp_pkg::PH_CSUM;
      end else if (ph == mdbfp_pkg::PH_CSUM) begin
         entry_limits(len, hdl);
         if (sum != data) begin
            add_due(mdbfp_pkg::ST_CSUM_BAD, cur_cmd, cur_sub, data, 6'd0, 1'b1);
            drop_frame();
         end else if (!hdl) begin
            add_due(mdbfp_pkg::ST_NO_HANDLER, cur_cmd, cur_sub, data, 6'd0, 1'b1);
            drop_frame();
         end else begin
            for (int i = 0; i < held; i++)
               add_due(mdbfp_pkg::ST_BYTE, cur_cmd, cur_sub, frame_bytes[i], 6'(i),
                       i + 1 == held);
            ph = mdbfp_pkg::PH_DONE;
         end
      end
   endfunction

   // stimulus helpers
   function automatic void queue_word(input logic [8:0] w);
      parser_item_type it;
      it = '{1'b0, w, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
             3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))};
      items_queued.push_back(it);
      items_sent++;
   endfunction

   function automatic void queue_define(input logic [2:0] c, input logic use_sub,
                                        input logic [2:0] s, input logic [5:0] len,
                                        input logic hdl);
      parser_item_type it;
      it = '{1'b1, 9'($urandom_range(0, 511)), c, use_sub, s, len, hdl};
      items_queued.push_back(it);
      items_sent++;
   endfunction

   function automatic logic [5:0] rand_len();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 6'd0;
      if (r == 1) return 6'(MAXF);
      if (r < 4) return 6'($urandom_range(20, MAXF));
      if (r < 7) return 6'd1;
      return 6'($urandom_range(2, 7));
   endfunction

   // sends a frame shaped to the table as it stands now
   function automatic void queue_frame(input logic [2:0] c, input logic [7:0] sub_byte,
                                       input bit bad_sum);
      logic [8:0] head;
      logic [7:0] total;
      logic [7:0] b;
      int n;
      int want;
      head = {1'b1, node_addr, c};
      queue_word(head);
      if (!tbl_valid[c]) return;
      total = head[7:0];
      n = 1;
      want = tbl_len[c];
      if (tbl_has_sub[c] && tbl_len[c] != 6'd1) begin
         queue_word({1'b0, sub_byte});
         total += sub_byte;
         n = 2;
         want = 0;
         if (sub_byte < NSUB && sub_valid[c][sub_byte[2:0]] &&
             sub_len[c][sub_byte[2:0]] >= 2)
            want = sub_len[c][sub_byte[2:0]];
      end
      if (want == 0) begin
         while (n <= MAXF) begin
            queue_word({1'b0, 8'($urandom_range(0, 255))});
            n++;
         end
         return;
      end
      while (n < want) begin
         b = 8'($urandom_range(0, 255));
         queue_word({1'b0, b});
         total += b;
         n++;
      end
      if (bad_sum) total ^= 8'($urandom_range(1, 255));
      queue_word({1'b0, total});
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (items_taken != items_sent || results_due.size() != 0);
   endtask

   task automatic write_address(input logic [4:0] a);
      wait_idle();
      repeat (20) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.device_address <= a;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      node_addr = a;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            step_parser(bus_item);
            items_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0 || items_queued.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_if.valid <= 1'b0;
            end else begin
               bus_item = items_queued.pop_front();
               req_if.cmd <= bus_item.cmd;
               req_if.bus_word <= bus_item.word;
               req_if.def_command <= bus_item.d_cmd;
               req_if.def_uses_sub <= bus_item.d_sub_en;
               req_if.def_subcommand <= bus_item.d_sub;
               req_if.def_length <= bus_item.d_len;
               req_if.def_has_handler <= bus_item.d_hdl;
               req_if.valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{mdbfp_pkg::status_type'(rsp_if.status), rsp_if.command_code,
                    rsp_if.subcommand_code, rsp_if.byte_value, rsp_if.byte_index,
                    rsp_if.last};
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item st=%0d cmd=%0d sub=%h val=%h idx=%0d last=%0d",
                        $time, got.status, got.cmd, got.sub, got.value, got.index, got.last);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected st=%0d cmd=%0d sub=%h val=%h idx=%0d last=%0d",
                           $time, want.status, want.cmd, want.sub, want.value, want.index,
                           want.last);
                  $display("%0t: actual   st=%0d cmd=%0d sub=%h val=%h idx=%0d last=%0d",
                           $time, got.status, got.cmd, got.sub, got.value, got.index,
                           got.last);
               end
            end
         end
         if (pat_pos == 4'd15)
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
         pat_pos = pat_pos + 4'd1;
         rsp_if.ready <= stall_pat[pat_pos];
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int goal;
      int pick;
      int k;
      int p;
      int c;
      int m;
      logic [2:0] cc;
      req_if.valid = 1'b0;
      req_if.cmd = 1'b0;
      req_if.bus_word = '0;
      req_if.def_command = '0;
      req_if.def_uses_sub = 1'b0;
      req_if.def_subcommand = '0;
      req_if.def_length = '0;
      req_if.def_has_handler = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.device_address = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: idle word, unknown command, table setup
      queue_word(9'h0A5);
      queue_frame(3'd5, 8'd0, 1'b0);
      queue_define(3'd1, 1'b0, 3'd0, 6'd3, 1'b1);
      queue_define(3'd7, 1'b0, 3'd0, 6'd2, 1'b0);
      queue_define(3'd3, 1'b1, 3'd2, 6'd4, 1'b1);
      queue_define(3'd4, 1'b0, 3'd0, 6'd1, 1'b1);
      queue_define(3'd4, 1'b1, 3'd6, 6'd5, 1'b1);
      wait_idle();
      // good frame with extreme bytes, then a word ignored after success
      queue_word(9'h111);
      queue_word(9'h0FF);
      queue_word(9'h000);
      queue_word(9'h010);
      queue_word(9'h055);
      queue_frame(3'd7, 8'd0, 1'b0);
      queue_frame(3'd1, 8'd0, 1'b1);
      queue_frame(3'd3, 8'd2, 1'b0);
      // subcommand table with top length one
      queue_frame(3'd4, 8'd0, 1'b0);
      // other address drops the frame
      queue_word(9'h111);
      queue_word({1'b1, 5'd31, 3'd1});

      for (p = 0; p < 4; p++) begin
         if (p == 0) write_address(5'd0);
         else if (p == 1) write_address(5'd31);
         else write_address(5'($urandom_range(0, 31)));
         for (c = 0; c < 8; c++) begin
            if ($urandom_range(0, 3) != 0) begin
               if ($urandom_range(0, 2) == 0) begin
                  m = $urandom_range(1, 5);
                  repeat (m) queue_define(3'(c), 1'b1, 3'($urandom_range(0, 7)), rand_len(),
                                          $urandom_range(0, 4) != 0);
               end else begin
                  queue_define(3'(c), 1'b0, 3'($urandom_range(0, 7)), rand_len(),
                               $urandom_range(0, 4) != 0);
               end
            end
         end
         wait_idle();
         goal = items_sent + 100;
         while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            cc = 3'($urandom_range(0, 7));
            if (pick < 65) begin
               queue_frame(cc, 8'($urandom_range(0, 7)), $urandom_range(0, 9) == 0);
            end else if (pick < 73) begin
               queue_define(cc, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                            rand_len(), 1'($urandom_range(0, 1)));
            end else if (pick < 85) begin
               queue_word(9'($urandom_range(0, 511)));
            end else if (pick < 97) begin
               // broken frame: cut short, maybe by another address
               queue_word({1'b1, node_addr, cc});
               k = $urandom_range(0, 3);
               repeat (k) queue_word({1'b0, 8'($urandom_range(0, 255))});
               if ($urandom_range(0, 1) == 1)
                  queue_word({1'b1, node_addr ^ 5'($urandom_range(1, 31)),
                              3'($urandom_range(0, 7))});
            end else begin
               queue_frame(cc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mdbfp_pkg.sv
rtl/mdbfp_ifs.sv
rtl/mdbfp_cmd_table.sv
rtl/mdbfp_frame_ram.sv
rtl/mdb_peripheral_frame_parser_core.sv
rtl/mdbfp_checker.sv
dv/tb.sv
